/* hw/rtl/cardinal_spline_point_generator_macros.svh */
// Assertion helpers for the spline point generator.
`ifndef CARDINAL_SPLINE_POINT_GENERATOR_MACROS_SVH
`define CARDINAL_SPLINE_POINT_GENERATOR_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is low.
`define CSP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("csp assertion failed");
// Next-cycle implication, disabled while reset is low.
`define CSP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("csp assertion failed");
`else
`define CSP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CSP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* hw/rtl/csp_pkg.sv */
`default_nettype none
package csp_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int MAX_POINTS_PER_SEGMENT = 31;
  localparam int PPS_W = 5;
  localparam int TEN_W = 17;
  localparam int T_W = 17;
  localparam int CNT_W = 6;
  localparam int CFG_IDX_W = 1;

  // control point: mirrored points need two extra bits
  localparam int CP_W = COORD_WIDTH + 2;
  localparam int CH_W = CP_W - 16;
  localparam int CL_W = 16;
  localparam int H_W = 20;
  localparam int HI_W = H_W + CH_W;
  localparam int LO_W = H_W + CL_W + 1;
  localparam int SUM_HI_W = HI_W + 2;
  localparam int SUM_LO_W = LO_W + 2;
  localparam int RES_W = SUM_HI_W + 1;
  localparam int PIPE_DEPTH = 7;

  localparam logic [CFG_IDX_W-1:0] REG_PPS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TENSION = 1'd1;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [CP_W-1:0] cp_t;
  typedef logic signed [H_W-1:0] h_t;

  typedef enum logic [1:0] {
    SEG_OPEN,
    SEG_CLOSE,
    SEG_LINEAR,
    SEG_ECHO
  } seg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OPEN,
    ST_CLOSE,
    ST_LINEAR,
    ST_ECHO,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    logic valid;
    seg_e seg;
    logic last;
  } tag_t;

  // 65536 / n and 65536 % n, index n (entry 0 acts as n = 1)
  localparam logic [T_W-1:0] T_STEP_Q [32] = '{
    17'd65536, 17'd65536, 17'd32768, 17'd21845, 17'd16384, 17'd13107, 17'd10922, 17'd9362,
    17'd8192,  17'd7281,  17'd6553,  17'd5957,  17'd5461,  17'd5041,  17'd4681,  17'd4369,
    17'd4096,  17'd3855,  17'd3640,  17'd3449,  17'd3276,  17'd3120,  17'd2978,  17'd2849,
    17'd2730,  17'd2621,  17'd2520,  17'd2427,  17'd2340,  17'd2259,  17'd2184,  17'd2114
  };
  localparam logic [PPS_W-1:0] T_STEP_R [32] = '{
    5'd0,  5'd0,  5'd0,  5'd1,  5'd0,  5'd1,  5'd4,  5'd2,
    5'd0,  5'd7,  5'd6,  5'd9,  5'd4,  5'd3,  5'd2,  5'd1,
    5'd0,  5'd1,  5'd16, 5'd5,  5'd16, 5'd16, 5'd20, 5'd9,
    5'd16, 5'd11, 5'd16, 5'd7,  5'd16, 5'd25, 5'd16, 5'd2
  };

endpackage
`default_nettype wire

/* hw/rtl/cardinal_spline_point_generator.sv */
// Cardinal spline point generator.
// Input channel (in_valid_i/in_ready_o) carries one keypoint per transaction,
// x/y/z in signed Q16.16 plus last_key marking the end of a path. Output
// channel (out_valid_o/out_ready_i) carries one generated point per transaction.
// Configuration: cfg_we_i writes register cfg_index_i (0: points per segment,
// 1: tension in Q1.16); write only while the block is idle.
// A keypoint is taken while in_ready_o is high, i.e. the previous keypoint's
// points have all left the seven-stage point pipeline (basis, lanes, merge).
// Points are issued one per cycle unless the receiver stalls; out_valid_o rises
// once a keypoint's first point has passed the point pipeline. From the third
// keypoint on, a keypoint yields n points (n = points per segment, 0 acting as 1),
// the closing one 2n+1, the second of a two-key path n+1, a lone keypoint 1.
// The output register is the last pipeline stage: when the receiver stalls,
// the whole point pipeline holds and issue pauses; nothing is dropped.
// Reset empties the pipeline, clears the key history and loads the register
// defaults (16 points per segment, tension 0.5).
`default_nettype none
`include "cardinal_spline_point_generator_macros.svh"
module cardinal_spline_point_generator
  import csp_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [TEN_W-1:0]     cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire coord_t               key_x_i,
  input  wire coord_t               key_y_i,
  input  wire coord_t               key_z_i,
  input  wire logic                 last_key_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output coord_t                    point_x_o,
  output coord_t                    point_y_o,
  output coord_t                    point_z_o,
  output logic                      last_point_o
);

  localparam logic [TEN_W-1:0] ONE_Q16 = 17'd65536;

  function automatic cp_t widen(input coord_t a);
    cp_t w;
    w = a;
    return w;
  endfunction

  function automatic cp_t mirror_pt(input coord_t a, input coord_t b);
    cp_t wa, wb;
    wa = a;
    wb = b;
    return (wa <<< 1) - wb;
  endfunction

  // configuration registers
  logic [PPS_W-1:0] pps_q;
  logic [TEN_W-1:0] ten_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pps_q <= 5'd16;
      ten_q <= 17'd32768;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_PPS:     pps_q <= cfg_data_i[PPS_W-1:0];
        REG_TENSION: ten_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [PPS_W-1:0] n_eff;
  logic [TEN_W-1:0] ten_sat;
  logic [TEN_W-1:0] alpha;

  always_comb begin
    if (pps_q == '0) begin
      n_eff = PPS_W'(1);
    end else if (pps_q > PPS_W'(MAX_POINTS_PER_SEGMENT)) begin
      n_eff = PPS_W'(MAX_POINTS_PER_SEGMENT);
    end else begin
      n_eff = pps_q;
    end
    ten_sat = (ten_q > ONE_Q16) ? ONE_Q16 : ten_q;
    alpha = ONE_Q16 - ten_sat;
  end

  // sequencer state
  state_e           state_q, state_d;
  logic [1:0]       ks_q, ks_d;
  coord_t           hist_q [3][3];
  coord_t           hist_d [3][3];
  coord_t           key_q [3];
  coord_t           key_d [3];
  logic             last_q, last_d;
  logic [CNT_W-1:0] j_q, j_d;
  logic [T_W-1:0]   tq_q, tq_d;
  logic [PPS_W-1:0] tr_q, tr_d;
  tag_t             tag_q [PIPE_DEPTH];

  logic             en;
  logic             emitting;
  logic             issue;
  logic             seg_end;
  logic             issue_last;
  logic             pipe_busy;
  seg_e             seg_cur;
  logic [CNT_W-1:0] lim;
  logic [PPS_W:0]   sum_r;
  logic             wrap;

  // whole point pipeline advances unless the output register is held
  assign en = !tag_q[PIPE_DEPTH-1].valid || out_ready_i;

  always_comb begin
    pipe_busy = 1'b0;
    for (int s = 0; s < PIPE_DEPTH; s++) begin
      pipe_busy = pipe_busy | tag_q[s].valid;
    end
  end

  always_comb begin
    emitting = 1'b1;
    seg_cur = SEG_OPEN;
    lim = '0;
    unique case (state_q)
      ST_OPEN: begin
        seg_cur = SEG_OPEN;
        lim = {1'b0, n_eff} - CNT_W'(1);
      end
      ST_CLOSE: begin
        seg_cur = SEG_CLOSE;
        lim = {1'b0, n_eff} - CNT_W'(1);
      end
      ST_LINEAR: begin
        seg_cur = SEG_LINEAR;
        lim = {1'b0, n_eff};
      end
      ST_ECHO: begin
        seg_cur = SEG_ECHO;
        lim = '0;
      end
      default: emitting = 1'b0;
    endcase
  end

  assign issue = emitting && en;
  assign seg_end = (j_q == lim);
  assign issue_last = (state_q == ST_ECHO) || ((state_q == ST_LINEAR) && seg_end);

  // t = floor(j * 65536 / n), advanced by quotient and remainder steps
  assign sum_r = {1'b0, tr_q} + {1'b0, T_STEP_R[n_eff]};
  assign wrap = (sum_r >= {1'b0, n_eff});

  always_comb begin
    state_d = state_q;
    ks_d = ks_q;
    hist_d = hist_q;
    key_d = key_q;
    last_d = last_q;
    j_d = j_q;
    tq_d = tq_q;
    tr_d = tr_q;
    in_ready_o = 1'b0;

    if (issue) begin
      if (seg_end) begin
        j_d = '0;
        tq_d = '0;
        tr_d = '0;
      end else begin
        j_d = j_q + CNT_W'(1);
        tq_d = tq_q + T_STEP_Q[n_eff] + T_W'(wrap);
        tr_d = wrap ? PPS_W'(sum_r - {1'b0, n_eff}) : sum_r[PPS_W-1:0];
      end
    end

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          key_d[0] = key_x_i;
          key_d[1] = key_y_i;
          key_d[2] = key_z_i;
          last_d = last_key_i;
          unique case (ks_q)
            2'd0:    state_d = last_key_i ? ST_ECHO : ST_DRAIN;
            2'd1:    state_d = last_key_i ? ST_LINEAR : ST_DRAIN;
            default: state_d = ST_OPEN;
          endcase
        end
      end
      ST_OPEN: begin
        if (issue && seg_end) begin
          state_d = last_q ? ST_CLOSE : ST_DRAIN;
        end
      end
      ST_CLOSE: begin
        if (issue && seg_end) begin
          state_d = ST_ECHO;
        end
      end
      ST_LINEAR, ST_ECHO: begin
        if (issue && seg_end) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // history changes only once no point in flight still reads it
        if (!pipe_busy) begin
          state_d = ST_IDLE;
          if (last_q) begin
            for (int e = 0; e < 3; e++) begin
              for (int ax = 0; ax < 3; ax++) begin
                hist_d[e][ax] = '0;
              end
            end
            ks_d = '0;
          end else begin
            hist_d[0] = hist_q[1];
            hist_d[1] = hist_q[2];
            hist_d[2] = key_q;
            ks_d = (ks_q == 2'd3) ? 2'd3 : ks_q + 2'd1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ks_q <= '0;
      last_q <= 1'b0;
      j_q <= '0;
      tq_q <= '0;
      tr_q <= '0;
      for (int e = 0; e < 3; e++) begin
        for (int ax = 0; ax < 3; ax++) begin
          hist_q[e][ax] <= '0;
        end
      end
    end else begin
      state_q <= state_d;
      ks_q <= ks_d;
      last_q <= last_d;
      j_q <= j_d;
      tq_q <= tq_d;
      tr_q <= tr_d;
      hist_q <= hist_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  // tag line: valid, segment kind and last flag ride along each point
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < PIPE_DEPTH; s++) begin
        tag_q[s] <= '0;
      end
    end else if (en) begin
      tag_q[0].valid <= issue;
      tag_q[0].seg <= seg_cur;
      tag_q[0].last <= issue_last;
      for (int s = 1; s < PIPE_DEPTH; s++) begin
        tag_q[s] <= tag_q[s-1];
      end
    end
  end

  // basis weights
  h_t h [4];

  csp_basis u_basis (
    .clk_i    (clk_i),
    .en_i     (en),
    .t_i      (tq_q),
    .alpha_i  (alpha),
    .linear_i ((seg_cur == SEG_LINEAR) || (seg_cur == SEG_ECHO)),
    .h_o      (h)
  );

  // control points for the segment of the point now at the lane input
  cp_t cp_sel [4][3];

  always_comb begin
    for (int ax = 0; ax < 3; ax++) begin
      unique case (tag_q[3].seg)
        SEG_OPEN: begin
          cp_sel[0][ax] = (ks_q == 2'd2) ? mirror_pt(hist_q[1][ax], hist_q[2][ax])
                                         : widen(hist_q[0][ax]);
          cp_sel[1][ax] = widen(hist_q[1][ax]);
          cp_sel[2][ax] = widen(hist_q[2][ax]);
          cp_sel[3][ax] = widen(key_q[ax]);
        end
        SEG_CLOSE: begin
          cp_sel[0][ax] = widen(hist_q[1][ax]);
          cp_sel[1][ax] = widen(hist_q[2][ax]);
          cp_sel[2][ax] = widen(key_q[ax]);
          cp_sel[3][ax] = mirror_pt(key_q[ax], hist_q[2][ax]);
        end
        SEG_LINEAR: begin
          cp_sel[0][ax] = widen(hist_q[2][ax]);
          cp_sel[1][ax] = widen(hist_q[2][ax]);
          cp_sel[2][ax] = widen(key_q[ax]);
          cp_sel[3][ax] = widen(key_q[ax]);
        end
        default: begin
          for (int l = 0; l < 4; l++) begin
            cp_sel[l][ax] = widen(key_q[ax]);
          end
        end
      endcase
    end
  end

  // one lane per control point
  logic signed [HI_W-1:0] hi [4][3];
  logic signed [LO_W-1:0] lo [4][3];

  for (genvar l = 0; l < 4; l++) begin : g_lane
    csp_lane u_lane (
      .clk_i (clk_i),
      .en_i  (en),
      .h_i   (h[l]),
      .cp_i  (cp_sel[l]),
      .hi_o  (hi[l]),
      .lo_o  (lo[l])
    );
  end

  coord_t pt [3];

  csp_merge u_merge (
    .clk_i (clk_i),
    .en_i  (en),
    .hi_i  (hi),
    .lo_i  (lo),
    .pt_o  (pt)
  );

  assign out_valid_o = tag_q[PIPE_DEPTH-1].valid;
  assign last_point_o = tag_q[PIPE_DEPTH-1].last;
  assign point_x_o = pt[0];
  assign point_y_o = pt[1];
  assign point_z_o = pt[2];

  // a new keypoint is only taken with an empty point pipeline
  `CSP_ASSERT_IMP(a_idle_empty, clk_i, rst_ni, state_q == ST_IDLE, !pipe_busy)
  // the closing point leaves while the sequencer waits for the drain
  `CSP_ASSERT_IMP(a_last_in_drain, clk_i, rst_ni, out_valid_o && last_point_o,
                  state_q == ST_DRAIN)
  // an accepted keypoint always starts work
  `CSP_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, in_valid_i && in_ready_o,
                  state_q != ST_IDLE)

endmodule
`default_nettype wire

/* hw/rtl/csp_basis.sv */
`default_nettype none
module csp_basis
  import csp_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic           en_i,
  input  wire logic [T_W-1:0] t_i,
  input  wire logic [T_W-1:0] alpha_i,
  input  wire logic           linear_i,
  output h_t                  h_o [4]
);

  localparam int T2_W = 2 * T_W;
  localparam int T3R_W = T2_W + T_W;
  localparam int T3_W = T3R_W - 16;
  localparam int M_W = 56;
  localparam logic signed [M_W-1:0] RND_HALF = {{(M_W-32){1'b0}}, 1'b1, 31'b0};
  localparam logic signed [M_W-1:0] ONE_Q48 = {{(M_W-49){1'b0}}, 1'b1, 48'b0};

  function automatic h_t round_q48(input logic signed [M_W-1:0] v);
    logic signed [M_W-1:0] s;
    s = (v + RND_HALF) >>> 32;
    return s[H_W-1:0];
  endfunction

  // stage 1: t^2
  logic [T_W-1:0]   t1_q, t2s_q, t3s_q;
  logic [T_W-1:0]   a1_q, a2_q;
  logic             lin1_q, lin2_q, lin3_q;
  logic [T2_W-1:0]  tt1_q, tt2_q;
  // stage 2: t^3 rounded
  logic [T3R_W-1:0] t3r;
  logic [T3R_W-1:0] t3r_rnd;
  logic [T3_W-1:0]  t3_q;

  assign t3r = tt1_q * t1_q;
  assign t3r_rnd = t3r + T3R_W'(32768);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t1_q   <= t_i;
      a1_q   <= alpha_i;
      lin1_q <= linear_i;
      tt1_q  <= t_i * t_i;
      t2s_q  <= t1_q;
      a2_q   <= a1_q;
      lin2_q <= lin1_q;
      tt2_q  <= tt1_q;
      t3_q   <= t3r_rnd[T3R_W-1:16];
    end
  end

  // stage 3: weight products
  logic signed [T_W:0]    a_s;
  logic signed [T_W+1:0]  k1, k2, k3, k4;
  logic signed [T3_W:0]   t3v;
  logic signed [T2_W:0]   t2v;
  logic signed [T_W+16:0] t1v;
  logic signed [T3_W+2:0] u0;
  logic signed [M_W-1:0]  p0_d, p1a_d, p1b_d, p2a_d, p2b_d, p2c_d, p3_d;
  logic signed [M_W-1:0]  p0_q, p1a_q, p1b_q, p2a_q, p2b_q, p2c_q, p3_q;

  always_comb begin
    a_s = $signed({1'b0, a2_q});
    t3v = $signed({1'b0, t3_q});
    t2v = $signed({1'b0, tt2_q});
    t1v = $signed({1'b0, t2s_q, 16'b0});
    k1 = 19'sh20000 - a_s;
    k2 = a_s - 19'sh30000;
    k3 = a_s - 19'sh20000;
    k4 = 19'sh30000 - (a_s <<< 1);
    u0 = (t2v <<< 1) - t3v - t1v;
    p0_d = a_s * u0;
    p1a_d = k1 * t3v;
    p1b_d = k2 * t2v;
    p2a_d = k3 * t3v;
    p2b_d = k4 * t2v;
    p2c_d = a_s * t1v;
    p3_d = a_s * (t3v - t2v);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0_q   <= p0_d;
      p1a_q  <= p1a_d;
      p1b_q  <= p1b_d;
      p2a_q  <= p2a_d;
      p2b_q  <= p2b_d;
      p2c_q  <= p2c_d;
      p3_q   <= p3_d;
      t3s_q  <= t2s_q;
      lin3_q <= lin2_q;
    end
  end

  // stage 4: sum and round to Q16; linear mode takes 1-t and t
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (lin3_q) begin
        h_o[0] <= '0;
        h_o[1] <= $signed(H_W'(18'h10000 - {1'b0, t3s_q}));
        h_o[2] <= $signed(H_W'(t3s_q));
        h_o[3] <= '0;
      end else begin
        h_o[0] <= round_q48(p0_q);
        h_o[1] <= round_q48(p1a_q + p1b_q + ONE_Q48);
        h_o[2] <= round_q48(p2a_q + p2b_q + p2c_q);
        h_o[3] <= round_q48(p3_q);
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/csp_lane.sv */
`default_nettype none
module csp_lane
  import csp_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              en_i,
  input  wire h_t                h_i,
  input  wire cp_t               cp_i [3],
  output logic signed [HI_W-1:0] hi_o [3],
  output logic signed [LO_W-1:0] lo_o [3]
);

  // split each control point into integer and fraction halves
  logic signed [CH_W-1:0] ch [3];
  logic signed [CL_W:0]   cl [3];

  always_comb begin
    for (int ax = 0; ax < 3; ax++) begin
      ch[ax] = cp_i[ax][CP_W-1:16];
      cl[ax] = $signed({1'b0, cp_i[ax][15:0]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int ax = 0; ax < 3; ax++) begin
        hi_o[ax] <= h_i * ch[ax];
        lo_o[ax] <= h_i * cl[ax];
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/csp_merge.sv */
`default_nettype none
module csp_merge
  import csp_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   en_i,
  input  wire logic signed [HI_W-1:0] hi_i [4][3],
  input  wire logic signed [LO_W-1:0] lo_i [4][3],
  output coord_t                      pt_o [3]
);

  localparam logic signed [SUM_LO_W-1:0] LO_HALF = {{(SUM_LO_W-16){1'b0}}, 1'b1, 15'b0};
  localparam logic signed [RES_W-1:0] SAT_HI =
    {{(RES_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [RES_W-1:0] SAT_LO =
    {{(RES_W-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

  logic signed [SUM_HI_W-1:0] shi_d [3];
  logic signed [SUM_LO_W-1:0] slo_d [3];
  logic signed [SUM_HI_W-1:0] shi_q [3];
  logic signed [SUM_LO_W-1:0] slo_q [3];
  logic signed [SUM_LO_W-1:0] lr [3];
  logic signed [RES_W-1:0]    res [3];
  coord_t                     pt_d [3];

  // add the four lanes
  always_comb begin
    for (int ax = 0; ax < 3; ax++) begin
      shi_d[ax] = '0;
      slo_d[ax] = '0;
      for (int l = 0; l < 4; l++) begin
        shi_d[ax] = shi_d[ax] + hi_i[l][ax];
        slo_d[ax] = slo_d[ax] + lo_i[l][ax];
      end
    end
  end

  // round the fraction sum, add, saturate
  always_comb begin
    for (int ax = 0; ax < 3; ax++) begin
      lr[ax] = (slo_q[ax] + LO_HALF) >>> 16;
      res[ax] = shi_q[ax] + lr[ax];
      if (res[ax] > SAT_HI) begin
        pt_d[ax] = SAT_HI[COORD_WIDTH-1:0];
      end else if (res[ax] < SAT_LO) begin
        pt_d[ax] = SAT_LO[COORD_WIDTH-1:0];
      end else begin
        pt_d[ax] = res[ax][COORD_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      shi_q <= shi_d;
      slo_q <= slo_d;
      pt_o  <= pt_d;
    end
  end

endmodule
`default_nettype wire
